// ===== design/pmmu_pkg.sv =====
// Shared types, constants and codes for the paged MMU with local LRU replacement.
package pmmu_pkg;

  localparam int NUM_PROCESSES_DEF     = 6;
  localparam int PAGES_PER_PROCESS_DEF = 32;
  localparam int NUM_FRAMES_DEF        = 32;

  localparam int CFG_W     = 6;
  localparam int NUM_CFG   = 7;
  localparam int CIDX_W    = 3;
  localparam int PID_W     = 3;
  localparam int PAGE_W    = 5;
  localparam int STATUS_W  = 3;
  localparam int REPLY_W   = 6;
  localparam int FAULT_W   = 16;
  localparam int STAMP_W   = 27;

  localparam logic [STAMP_W-1:0] CLOCK_MAX = 27'd99999999;
  localparam logic [FAULT_W-1:0] FAULT_MAX = 16'hFFFF;

  localparam logic [CIDX_W-1:0] REG_FRAME_COUNT = 3'd6;

  localparam logic [REPLY_W-1:0] REPLY_FAULT = 6'b111111;
  localparam logic [REPLY_W-1:0] REPLY_RANGE = 6'b111110;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT        = 3'd0,
    ST_ALLOC      = 3'd1,
    ST_REPLACED   = 3'd2,
    ST_UNRESOLVED = 3'd3,
    ST_RANGE      = 3'd4,
    ST_TERMINATED = 3'd5
  } status_t;

  // controller -> datapath commands
  typedef struct packed {
    logic capture;      // latch the request
    logic scan_clr;     // reset scan index and search registers
    logic vscan_start;  // with scan_clr: enter victim scan mode
    logic scan_step;    // evaluate current index, advance
    logic read_entry;   // load entry at scan index
    logic read_req;     // load entry at requested page
    logic term_free;    // free frame of the loaded entry, clear it
    logic commit_hit;
    logic commit_alloc;
    logic read_victim;
    logic commit_repl;  // clear victim, write request page
    logic finish_fault; // count fault, build fault result
    logic result_simple;
    logic out_load;
  } pmmu_cmd_t;

  typedef struct packed {
    logic req_term;
    logic proc_bad;
    logic out_range;
    logic entry_valid;
    logic scan_done;
    logic free_found;
    logic victim_found;
    logic out_busy;
  } pmmu_stat_t;

endpackage

// ===== design/pmmu_ram.sv =====
// Generic single-port RAM with registered read.
module pmmu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== design/pmmu_ctrl.sv =====
// Controller state machine sequencing lookups, scans and table updates.
module pmmu_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  pmmu_pkg::pmmu_stat_t   stat,
  output pmmu_pkg::pmmu_cmd_t    cmd
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_DECODE = 11'b00000000010,
    S_TRD    = 11'b00000000100,
    S_TFREE  = 11'b00000001000,
    S_LOOK   = 11'b00000010000,
    S_LWAIT  = 11'b00000100000,
    S_LCHK   = 11'b00001000000,
    S_FSCAN  = 11'b00010000000,
    S_VSCAN  = 11'b00100000000,
    S_VRD    = 11'b01000000000,
    S_DONE   = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   vread_r, vread_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    vread_nxt = vread_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.scan_clr = 1'b1;
        if (stat.proc_bad || (!stat.req_term && stat.out_range)) begin
          cmd.result_simple = 1'b1;
          state_nxt         = S_DONE;
        end else if (stat.req_term) begin
          state_nxt = S_TRD;
        end else begin
          state_nxt = S_LOOK;
        end
      end
      S_TRD: begin
        if (stat.scan_done) begin
          cmd.result_simple = 1'b1;
          state_nxt         = S_DONE;
        end else begin
          cmd.read_entry = 1'b1;
          state_nxt      = S_TFREE;
        end
      end
      S_TFREE: begin
        cmd.term_free = 1'b1;
        state_nxt     = S_TRD;
      end
      S_LOOK: begin
        cmd.read_req = 1'b1;
        state_nxt    = S_LWAIT;
      end
      S_LWAIT: begin
        // hold the address so the read data belongs to the requested page
        cmd.read_req = 1'b1;
        state_nxt    = S_LCHK;
      end
      S_LCHK: begin
        if (stat.entry_valid) begin
          cmd.commit_hit = 1'b1;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_FSCAN;
        end
      end
      S_FSCAN: begin
        if (stat.free_found) begin
          cmd.commit_alloc = 1'b1;
          cmd.finish_fault = 1'b1;
          state_nxt        = S_DONE;
        end else if (stat.scan_done) begin
          cmd.scan_clr    = 1'b1;
          cmd.vscan_start = 1'b1;
          vread_nxt       = 1'b0;
          state_nxt       = S_VSCAN;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_VSCAN: begin
        // pipeline: issue read at idx, evaluate the data in the next cycle
        if (vread_r) begin
          cmd.scan_step = 1'b1;
        end
        if (stat.scan_done && vread_r) begin
          vread_nxt = 1'b0;
          if (stat.victim_found) begin
            cmd.read_victim = 1'b1;
            state_nxt       = S_VRD;
          end else begin
            cmd.finish_fault = 1'b1;
            state_nxt        = S_DONE;
          end
        end else begin
          cmd.read_entry = 1'b1;
          vread_nxt      = 1'b1;
        end
      end
      S_VRD: begin
        if (vread_r) begin
          cmd.commit_repl  = 1'b1;
          cmd.finish_fault = 1'b1;
          state_nxt        = S_DONE;
        end else begin
          // read again once the last evaluation has settled the victim
          cmd.read_victim = 1'b1;
          vread_nxt       = 1'b1;
        end
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vread_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vread_r <= vread_nxt;
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == S_IDLE) else $error("ready outside idle");
  a_capture: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r == S_DECODE) else $error("capture lost");
  a_out_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> state_r == S_IDLE) else $error("result not closed");
`endif

endmodule

// ===== design/pmmu_dp.sv =====
// Datapath: page tables, free map, clocks, fault counters, scan and output register.
module pmmu_dp #(
  parameter int NUM_PROCESSES     = pmmu_pkg::NUM_PROCESSES_DEF,
  parameter int PAGES_PER_PROCESS = pmmu_pkg::PAGES_PER_PROCESS_DEF,
  parameter int NUM_FRAMES        = pmmu_pkg::NUM_FRAMES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_req_type,
  input  logic [pmmu_pkg::PID_W-1:0]      in_process_id,
  input  logic [pmmu_pkg::PAGE_W-1:0]     in_page_number,
  input  logic                            cfg_we,
  input  logic [pmmu_pkg::CIDX_W-1:0]     cfg_index,
  input  logic [pmmu_pkg::CFG_W-1:0]      cfg_wdata,
  input  pmmu_pkg::pmmu_cmd_t             cmd,
  output pmmu_pkg::pmmu_stat_t            stat,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [pmmu_pkg::STATUS_W-1:0]   out_status,
  output logic signed [pmmu_pkg::REPLY_W-1:0] out_frame_reply,
  output logic [pmmu_pkg::FAULT_W-1:0]    out_fault_total
);

  localparam int PG_W   = (PAGES_PER_PROCESS > 1) ? $clog2(PAGES_PER_PROCESS) : 1;
  localparam int FR_W   = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int PR_W   = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
  localparam int ENT    = NUM_PROCESSES * PAGES_PER_PROCESS;
  localparam int ADDR_W = $clog2(ENT + 1);
  localparam int CNT_W  = $clog2(PAGES_PER_PROCESS + 1) > $clog2(NUM_FRAMES + 1) ?
                          $clog2(PAGES_PER_PROCESS + 1) : $clog2(NUM_FRAMES + 1);
  localparam int SCAN_W = CNT_W + 1;
  localparam int PEXT_W = (pmmu_pkg::PAGE_W > CNT_W) ? pmmu_pkg::PAGE_W + 1 : CNT_W + 1;
  localparam int FEXT_W = (FR_W > pmmu_pkg::REPLY_W) ? FR_W : pmmu_pkg::REPLY_W;

  // configuration registers
  logic [pmmu_pkg::CFG_W-1:0] pages_r [pmmu_pkg::NUM_CFG-1];
  logic [pmmu_pkg::CFG_W-1:0] fcount_r;

  // request
  logic                        term_r;
  logic [pmmu_pkg::PID_W-1:0]  pid_r;
  logic [pmmu_pkg::PAGE_W-1:0] page_r;

  // per-process clocks and fault counters, shared frame free map, entry valid bits
  logic [pmmu_pkg::STAMP_W-1:0] clock_r [NUM_PROCESSES];
  logic [pmmu_pkg::FAULT_W-1:0] fcnt_r  [NUM_PROCESSES];
  logic [NUM_FRAMES-1:0]        free_r;
  logic [ENT-1:0]               valid_r;

  // scan
  logic [SCAN_W-1:0]            idx_r;
  logic [PG_W-1:0]              last_idx_r;
  logic                         found_r;
  logic [PG_W-1:0]              victim_r;
  logic [pmmu_pkg::STAMP_W-1:0] best_r;
  logic                         cmd_vmode_r;

  // result staging
  logic [pmmu_pkg::STATUS_W-1:0] res_status_r;
  logic [pmmu_pkg::REPLY_W-1:0]  res_reply_r;
  logic [pmmu_pkg::FAULT_W-1:0]  res_total_r;
  logic                          out_valid_r;

  logic [PR_W-1:0] pidx;
  assign pidx = pid_r[PR_W-1:0];

  logic proc_bad;
  assign proc_bad = ({1'b0, pid_r} >= (pmmu_pkg::PID_W+1)'(NUM_PROCESSES));

  // usable page count and frame limit
  logic [CNT_W-1:0] kpages, mframes;
  logic [pmmu_pkg::CFG_W-1:0] kraw;
  always_comb begin
    kraw = '0;
    for (int i = 0; i < pmmu_pkg::NUM_CFG - 1; i++) begin
      if (pid_r == pmmu_pkg::PID_W'(i)) kraw = pages_r[i];
    end
    if (PEXT_W'(kraw) > PEXT_W'(PAGES_PER_PROCESS)) kpages = CNT_W'(PAGES_PER_PROCESS);
    else kpages = CNT_W'(kraw);
    if (PEXT_W'(fcount_r) > PEXT_W'(NUM_FRAMES)) mframes = CNT_W'(NUM_FRAMES);
    else mframes = CNT_W'(fcount_r);
  end

  logic out_range;
  assign out_range = PEXT_W'(page_r) >= PEXT_W'(kpages);

  // table RAMs
  logic                         ram_we;
  logic [ADDR_W-1:0]            ram_addr;
  logic [FR_W-1:0]              frame_wd, frame_rd;
  logic [pmmu_pkg::STAMP_W-1:0] stamp_wd, stamp_rd;
  logic [PG_W-1:0]              sel_page;
  logic                         rd_valid_r;

  always_comb begin
    if (cmd.read_req || cmd.commit_hit || cmd.commit_alloc || cmd.commit_repl)
      sel_page = page_r[PG_W-1:0];
    else if (cmd.read_victim)
      sel_page = victim_r;
    else if (cmd.term_free)
      sel_page = last_idx_r;
    else
      sel_page = idx_r[PG_W-1:0];
  end

  assign ram_addr = ADDR_W'(pidx) * ADDR_W'(PAGES_PER_PROCESS) + ADDR_W'(sel_page);

  logic [pmmu_pkg::STAMP_W-1:0] clk_bumped;
  assign clk_bumped = (clock_r[pidx] < pmmu_pkg::CLOCK_MAX) ? clock_r[pidx] + 1'b1
                                                            : clock_r[pidx];

  always_comb begin
    ram_we   = cmd.commit_hit || cmd.commit_alloc || cmd.commit_repl || cmd.term_free;
    stamp_wd = cmd.term_free ? '0 : clk_bumped;
    if (cmd.commit_alloc) frame_wd = idx_r[FR_W-1:0];
    else                  frame_wd = frame_rd;
  end

  pmmu_ram #(.WIDTH(FR_W), .DEPTH(ENT)) u_frame_ram (
    .clk(clk), .we(ram_we && !cmd.term_free && !cmd.commit_hit),
    .addr(ram_addr[$clog2(ENT)-1:0]), .wdata(frame_wd), .rdata(frame_rd));

  pmmu_ram #(.WIDTH(pmmu_pkg::STAMP_W), .DEPTH(ENT)) u_stamp_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr[$clog2(ENT)-1:0]),
    .wdata(stamp_wd), .rdata(stamp_rd));

  logic [ADDR_W-1:0] victim_addr;
  assign victim_addr = ADDR_W'(pidx) * ADDR_W'(PAGES_PER_PROCESS) + ADDR_W'(victim_r);

  // scan evaluation
  logic scan_done;
  logic [SCAN_W-1:0] scan_lim;
  assign scan_lim  = term_r ? SCAN_W'(PAGES_PER_PROCESS) : SCAN_W'(kpages);
  assign scan_done = term_r ? (idx_r >= scan_lim) :
                     (found_r ? 1'b0 : (idx_r >= SCAN_W'(mframes)));

  logic [SCAN_W-1:0] vlim;
  assign vlim = SCAN_W'(kpages);

  assign stat.req_term     = term_r;
  assign stat.proc_bad     = proc_bad;
  assign stat.out_range    = out_range;
  assign stat.entry_valid  = rd_valid_r;
  assign stat.scan_done    = term_r ? scan_done :
                             (cmd_vmode_r ? (idx_r >= vlim) : (idx_r >= SCAN_W'(mframes)));
  assign stat.free_found   = !cmd_vmode_r && (idx_r < SCAN_W'(mframes)) &&
                             free_r[idx_r[FR_W-1:0]];
  // count the entry still being evaluated at the end of the victim scan
  assign stat.victim_found = found_r || (cmd_vmode_r && rd_valid_r);
  assign stat.out_busy     = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < pmmu_pkg::NUM_CFG - 1; i++) pages_r[i] <= '0;
      fcount_r    <= pmmu_pkg::CFG_W'(32);
      for (int i = 0; i < NUM_PROCESSES; i++) begin
        clock_r[i] <= '0;
        fcnt_r[i]  <= '0;
      end
      free_r      <= '1;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      cmd_vmode_r <= 1'b0;
      idx_r       <= '0;
      found_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index < pmmu_pkg::REG_FRAME_COUNT) pages_r[cfg_index] <= cfg_wdata;
        else if (cfg_index == pmmu_pkg::REG_FRAME_COUNT) fcount_r <= cfg_wdata;
      end
      if (cmd.capture) begin
        term_r  <= in_req_type;
        pid_r   <= in_process_id;
        page_r  <= in_page_number;
      end
      if (cmd.scan_clr) begin
        cmd_vmode_r <= cmd.vscan_start;
        idx_r   <= '0;
        found_r <= 1'b0;
        best_r  <= '1;
      end
      if (cmd.read_entry) begin
        last_idx_r <= idx_r[PG_W-1:0];
        rd_valid_r <= valid_r[ram_addr[$clog2(ENT)-1:0]];
        if (term_r) idx_r <= idx_r + 1'b1;
      end
      if (cmd.read_req) rd_valid_r <= valid_r[ram_addr[$clog2(ENT)-1:0]];
      if (cmd.scan_step) begin
        if (cmd_vmode_r) begin
          // evaluate entry read last cycle
          if (rd_valid_r && stamp_rd < best_r) begin
            best_r   <= stamp_rd;
            victim_r <= last_idx_r;
            found_r  <= 1'b1;
          end
          idx_r <= idx_r + 1'b1;
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end
      if (cmd.term_free && rd_valid_r) begin
        if (FEXT_W'(frame_rd) < FEXT_W'(NUM_FRAMES)) free_r[frame_rd] <= 1'b1;
        valid_r[ram_addr[$clog2(ENT)-1:0]] <= 1'b0;
      end
      if (cmd.commit_hit) begin
        clock_r[pidx] <= clk_bumped;
        res_status_r  <= pmmu_pkg::ST_HIT;
        res_reply_r   <= pmmu_pkg::REPLY_W'(frame_rd);
        res_total_r   <= fcnt_r[pidx];
      end
      if (cmd.commit_alloc) begin
        free_r[idx_r[FR_W-1:0]] <= 1'b0;
        valid_r[ram_addr[$clog2(ENT)-1:0]] <= 1'b1;
        clock_r[pidx] <= clk_bumped;
      end
      if (cmd.commit_repl) begin
        valid_r[victim_addr[$clog2(ENT)-1:0]] <= 1'b0;
        valid_r[ram_addr[$clog2(ENT)-1:0]]    <= 1'b1;
        clock_r[pidx] <= clk_bumped;
      end
      if (cmd.finish_fault) begin
        if (fcnt_r[pidx] < pmmu_pkg::FAULT_MAX) begin
          fcnt_r[pidx] <= fcnt_r[pidx] + 1'b1;
          res_total_r  <= fcnt_r[pidx] + 1'b1;
        end else begin
          res_total_r  <= fcnt_r[pidx];
        end
        res_reply_r <= pmmu_pkg::REPLY_FAULT;
        if (cmd.commit_alloc)     res_status_r <= pmmu_pkg::ST_ALLOC;
        else if (cmd.commit_repl) res_status_r <= pmmu_pkg::ST_REPLACED;
        else                      res_status_r <= pmmu_pkg::ST_UNRESOLVED;
      end
      if (cmd.result_simple) begin
        if (term_r) begin
          res_status_r <= pmmu_pkg::ST_TERMINATED;
          res_reply_r  <= '0;
        end else begin
          res_status_r <= pmmu_pkg::ST_RANGE;
          res_reply_r  <= pmmu_pkg::REPLY_RANGE;
        end
        res_total_r <= proc_bad ? '0 : fcnt_r[pidx];
      end
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  logic [pmmu_pkg::STATUS_W-1:0] out_status_r;
  logic [pmmu_pkg::REPLY_W-1:0]  out_reply_r;
  logic [pmmu_pkg::FAULT_W-1:0]  out_total_r;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_reply_r  <= res_reply_r;
      out_total_r  <= res_total_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_frame_reply = out_reply_r;
  assign out_fault_total = out_total_r;

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid_r && !out_ready)) else $error("overwrite");
  a_alloc_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit_alloc |-> free_r[idx_r[FR_W-1:0]]) else $error("frame not free");
`endif

endmodule

// ===== design/paged_mmu_local_lru.sv =====
// Top level: paged MMU with per-process LRU replacement.
// Outcomes: out of range or unknown process, a hit, a fault that takes the first free
// frame among the m configured frames, or else one that replaces the least recently used
// of the k usable pages (unresolved if none is valid); terminate frees every page entry.
// One request at a time: the next is accepted in the cycle after the result is
// loaded, which waits while the previous result is not taken. Synchronous active-low
// reset clears all control, valid and free state at once.
module paged_mmu_local_lru #(
  parameter int NUM_PROCESSES     = pmmu_pkg::NUM_PROCESSES_DEF,
  parameter int PAGES_PER_PROCESS = pmmu_pkg::PAGES_PER_PROCESS_DEF,
  parameter int NUM_FRAMES        = pmmu_pkg::NUM_FRAMES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_req_type,
  input  logic [pmmu_pkg::PID_W-1:0]          in_process_id,
  input  logic [pmmu_pkg::PAGE_W-1:0]         in_page_number,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [pmmu_pkg::STATUS_W-1:0]       out_status,
  output logic signed [pmmu_pkg::REPLY_W-1:0] out_frame_reply,
  output logic [pmmu_pkg::FAULT_W-1:0]        out_fault_total,
  input  logic                                cfg_we,
  input  logic [pmmu_pkg::CIDX_W-1:0]         cfg_index,
  input  logic [pmmu_pkg::CFG_W-1:0]          cfg_wdata
);

  pmmu_pkg::pmmu_cmd_t  cmd;
  pmmu_pkg::pmmu_stat_t stat;

  pmmu_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .stat(stat), .cmd(cmd));

  pmmu_dp #(
    .NUM_PROCESSES(NUM_PROCESSES),
    .PAGES_PER_PROCESS(PAGES_PER_PROCESS),
    .NUM_FRAMES(NUM_FRAMES)
  ) u_dp (
    .clk(clk), .rst_n(rst_n),
    .in_req_type(in_req_type), .in_process_id(in_process_id),
    .in_page_number(in_page_number),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .cmd(cmd), .stat(stat),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_frame_reply(out_frame_reply), .out_fault_total(out_fault_total));

endmodule

// ===== dv/testbench.sv =====
// Testbench for the paged MMU with local LRU replacement: random and directed requests.
`timescale 1ns / 100ps

module testbench;

  localparam int NPROC  = 6;
  localparam int NPAGE  = 32;
  localparam int NFRAME = 32;
  localparam int LIMIT  = 2000000;

  // Page table model and result checker.
  class mmu_scoreboard;
    bit [5:0]                    page_limit[NPROC];
    bit [5:0]                    frames_used;
    bit                          pte_valid[NPROC][NPAGE];
    bit [4:0]                    pte_frame[NPROC][NPAGE];
    bit [pmmu_pkg::STAMP_W-1:0]  pte_stamp[NPROC][NPAGE];
    bit [pmmu_pkg::STAMP_W-1:0]  access_clock[NPROC];
    bit                          free_map[NFRAME];
    bit [pmmu_pkg::FAULT_W-1:0]  faults[NPROC];
    bit [pmmu_pkg::STATUS_W-1:0] exp_status[$];
    bit [pmmu_pkg::REPLY_W-1:0]  exp_reply[$];
    bit [pmmu_pkg::FAULT_W-1:0]  exp_faults[$];
    int errors;
    int checked;

    function new();
      foreach (page_limit[i]) page_limit[i] = 0;
      frames_used = 32;
      foreach (free_map[f]) free_map[f] = 1;
      foreach (access_clock[p]) begin
        access_clock[p] = 0;
        faults[p] = 0;
        for (int g = 0; g < NPAGE; g++) begin
          pte_valid[p][g] = 0;
          pte_frame[p][g] = 0;
          pte_stamp[p][g] = 0;
        end
      end
      errors = 0;
      checked = 0;
    endfunction

    function void write_reg(int idx, bit [5:0] val);
      if (idx == pmmu_pkg::REG_FRAME_COUNT) frames_used = val;
      else page_limit[idx] = val;
    endfunction

    function bit [pmmu_pkg::STAMP_W-1:0] tick(int p);
      if (access_clock[p] < pmmu_pkg::CLOCK_MAX) access_clock[p]++;
      return access_clock[p];
    endfunction

    function void push(pmmu_pkg::status_t s, bit [pmmu_pkg::REPLY_W-1:0] r,
                       bit [pmmu_pkg::FAULT_W-1:0] t);
      exp_status.push_back(s);
      exp_reply.push_back(r);
      exp_faults.push_back(t);
    endfunction

    function void note_request(bit term, bit [2:0] pid, bit [4:0] page);
      int p, k, m, f, victim;
      bit [pmmu_pkg::STAMP_W-1:0] best;
      pmmu_pkg::status_t st;
      p = pid;
      if (p >= NPROC) begin
        if (term) push(pmmu_pkg::ST_TERMINATED, 0, 0);
        else push(pmmu_pkg::ST_RANGE, pmmu_pkg::REPLY_RANGE, 0);
        return;
      end
      if (term) begin
        for (int i = 0; i < NPAGE; i++)
          if (pte_valid[p][i]) begin
            free_map[pte_frame[p][i]] = 1;
            pte_valid[p][i] = 0;
            pte_stamp[p][i] = 0;
          end
        push(pmmu_pkg::ST_TERMINATED, 0, faults[p]);
        return;
      end
      k = (page_limit[p] > NPAGE) ? NPAGE : page_limit[p];
      if (page >= k) begin
        push(pmmu_pkg::ST_RANGE, pmmu_pkg::REPLY_RANGE, faults[p]);
        return;
      end
      if (pte_valid[p][page]) begin
        pte_stamp[p][page] = tick(p);
        push(pmmu_pkg::ST_HIT, {1'b0, pte_frame[p][page]}, faults[p]);
        return;
      end
      st = pmmu_pkg::ST_UNRESOLVED;
      m = (frames_used > NFRAME) ? NFRAME : frames_used;
      for (f = 0; f < m; f++) if (free_map[f]) break;
      if (f < m) begin
        free_map[f] = 0;
        pte_frame[p][page] = 5'(f);
        pte_valid[p][page] = 1;
        pte_stamp[p][page] = tick(p);
        st = pmmu_pkg::ST_ALLOC;
      end else begin
        victim = -1;
        best = 27'd100000000;
        for (int i = 0; i < k; i++)
          if (pte_valid[p][i] && pte_stamp[p][i] < best) begin
            best = pte_stamp[p][i];
            victim = i;
          end
        if (victim >= 0) begin
          pte_valid[p][victim] = 0;
          pte_stamp[p][victim] = 0;
          pte_frame[p][page] = pte_frame[p][victim];
          pte_valid[p][page] = 1;
          pte_stamp[p][page] = tick(p);
          st = pmmu_pkg::ST_REPLACED;
        end
      end
      if (faults[p] < pmmu_pkg::FAULT_MAX) faults[p]++;
      push(st, pmmu_pkg::REPLY_FAULT, faults[p]);
    endfunction

    function void check_reply(bit [pmmu_pkg::STATUS_W-1:0] s, bit [pmmu_pkg::REPLY_W-1:0] r,
                              bit [pmmu_pkg::FAULT_W-1:0] t);
      if (exp_status.size() == 0) begin
        $error("unexpected reply: status %0d frame_reply %0d", s, $signed(r));
        errors++;
        return;
      end
      checked++;
      if (s !== exp_status[0]) begin
        $error("status: expected %0d, got %0d", exp_status[0], s);
        errors++;
      end
      if (r !== exp_reply[0]) begin
        $error("frame_reply: expected %0d, got %0d", $signed(exp_reply[0]), $signed(r));
        errors++;
      end
      if (t !== exp_faults[0]) begin
        $error("fault_total: expected %0d, got %0d", exp_faults[0], t);
        errors++;
      end
      void'(exp_status.pop_front());
      void'(exp_reply.pop_front());
      void'(exp_faults.pop_front());
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, in_req_type;
  logic [pmmu_pkg::PID_W-1:0] in_process_id;
  logic [pmmu_pkg::PAGE_W-1:0] in_page_number;
  logic out_valid, out_ready;
  logic [pmmu_pkg::STATUS_W-1:0] out_status;
  logic signed [pmmu_pkg::REPLY_W-1:0] out_frame_reply;
  logic [pmmu_pkg::FAULT_W-1:0] out_fault_total;
  logic cfg_we;
  logic [pmmu_pkg::CIDX_W-1:0] cfg_index;
  logic [pmmu_pkg::CFG_W-1:0] cfg_wdata;

  mmu_scoreboard sb;
  bit quiet_phase;
  int cycles;
  int sent;

  paged_mmu_local_lru uut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result side: random stalls, check every accepted reply.
  initial begin
    int gap;
    out_ready = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 11);
        out_ready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
      if (out_valid && out_ready)
        sb.check_reply(out_status, out_frame_reply, out_fault_total);
    end
  end

  // Valid stays high after an accept until the next request, an idle gap or a drain.
  task automatic send_request(bit term, bit [2:0] pid, bit [4:0] page);
    if (!quiet_phase && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1;
    in_req_type <= term;
    in_process_id <= pid;
    in_page_number <= page;
    do @(posedge clk); while (!in_ready);
    sb.note_request(term, pid, page);
    sent++;
  endtask

  task automatic write_reg(int idx, bit [5:0] val);
    cfg_we <= 1;
    cfg_index <= pmmu_pkg::CIDX_W'(idx);
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.exp_status.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_limits(bit [5:0] lo, bit [5:0] hi, bit [5:0] frames);
    for (int i = 0; i < NPROC; i++) write_reg(i, 6'($urandom_range(lo, hi)));
    write_reg(pmmu_pkg::REG_FRAME_COUNT, frames);
  endtask

  // Mostly legal pages of the six processes, some terminates and stray ids.
  task automatic random_phase(int n);
    bit [2:0] pid;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      pid = (r < 3) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      if (r >= 3 && r < 9) send_request(1, pid, 5'($urandom));
      else if (r < 94 && pid < NPROC && sb.page_limit[pid] > 0)
        send_request(0, pid, 5'($urandom_range(0, (sb.page_limit[pid] > 32 ? 32
                                                   : sb.page_limit[pid]) - 1)));
      else send_request(0, pid, 5'($urandom));
    end
  endtask

  initial begin
    sb = new();
    cycles = 0;
    sent = 0;
    quiet_phase = 0;
    rst_n = 0;
    in_valid = 0;
    in_req_type = 0;
    in_process_id = 0;
    in_page_number = 0;
    cfg_we = 0;
    cfg_index = 0;
    cfg_wdata = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: reset limits give out of range, then small frame pool.
    send_request(0, 0, 0);
    send_request(1, 7, 31);
    send_request(0, 6, 5);
    drain();
    write_reg(0, 63);
    write_reg(1, 4);
    write_reg(2, 0);
    write_reg(3, 32);
    write_reg(4, 1);
    write_reg(5, 2);
    write_reg(pmmu_pkg::REG_FRAME_COUNT, 3);
    send_request(0, 0, 31);
    send_request(0, 0, 0);
    send_request(0, 1, 3);
    send_request(0, 1, 4);
    send_request(0, 0, 31);
    send_request(0, 1, 0);
    send_request(0, 1, 2);
    send_request(0, 0, 5);
    send_request(0, 2, 0);
    send_request(0, 2, 0);
    send_request(1, 0, 0);
    send_request(0, 1, 1);
    send_request(0, 3, 31);
    drain();
    write_reg(pmmu_pkg::REG_FRAME_COUNT, 0);
    send_request(0, 4, 0);
    send_request(0, 1, 3);
    send_request(0, 1, 1);
    send_request(1, 1, 0);
    send_request(1, 5, 0);
    drain();

    set_limits(1, 8, 4);
    random_phase(120);
    drain();
    set_limits(16, 32, 32);
    random_phase(120);
    drain();
    set_limits(0, 63, 63);
    random_phase(100);
    drain();
    set_limits(2, 6, 6);
    quiet_phase = 1;
    random_phase(130);

    drain();
    $display("%0d requests sent, %0d replies checked over several page and frame limits",
             sent, sb.checked);
    if (sb.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
